// File: hdl/pkw_pkg.sv
package pkw_pkg;

    // Default sizes for the top-level parameters.
    localparam int CODES_PER_WORD_DEF = 9;
    localparam int BREAK_SLOTS_DEF    = 16;

    // Hard limits that follow from the fixed port widths.
    localparam int CODES_MAX     = 9;
    localparam int BREAK_SLOTS_MAX = 16;
    localparam int OUT_WORDS     = 3;
    localparam int CODES_PER_OUT = 3;

    // Five-bit code values.
    localparam logic [4:0] CODE_PAD     = 5'd5;
    localparam logic [4:0] CODE_ESCAPE  = 5'd6;
    localparam logic [4:0] SHIFT_UPPER  = 5'd4;
    localparam logic [4:0] SHIFT_PUNCT  = 5'd5;

    // Number of codes a single character can produce.
    localparam logic [2:0] LEN_LOWER = 3'd1;
    localparam logic [2:0] LEN_SHIFT = 3'd2;
    localparam logic [2:0] LEN_RAW   = 3'd4;

    // Configuration register indexes.
    localparam logic [0:0] CFG_BREAK_LOW  = 1'b0;
    localparam logic [0:0] CFG_BREAK_HIGH = 1'b1;

    // One input word of the character stream.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       word_start;
        logic       text_end;
    } t_in_word;

    // One encoded dictionary word.
    typedef struct packed {
        logic [15:0] packed_first;
        logic [15:0] packed_second;
        logic [15:0] packed_third;
        logic [7:0]  chars_consumed;
    } t_out_word;

    // Codes produced by one character, code[0] is emitted first.
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][4:0] code;
    } t_char_codes;

endpackage

// File: hdl/pkw_break_detect.sv
module pkw_break_detect #(
    parameter int BREAK_SLOTS = pkw_pkg::BREAK_SLOTS_DEF
) (
    input  logic [63:0] i_break_low,
    input  logic [63:0] i_break_high,
    input  logic [7:0]  i_char,
    output logic        o_is_break
);

    logic [127:0]                 w_all;
    logic [BREAK_SLOTS-1:0]       w_zero;
    logic [BREAK_SLOTS-1:0]       w_hit;

    assign w_all = {i_break_high, i_break_low};

    // Each slot matches only if no earlier slot holds the terminating zero byte.
    for (genvar k = 0; k < BREAK_SLOTS; k++) begin : g_slot
        localparam logic [BREAK_SLOTS-1:0] MASK = BREAK_SLOTS'((65'd1 << k) - 65'd1);
        assign w_zero[k] = (w_all[8*k +: 8] == 8'h00);
        assign w_hit[k]  = (w_all[8*k +: 8] == i_char) && !(|(w_zero & MASK));
    end

    // A zero character is always a break.
    assign o_is_break = (i_char == 8'h00) || (|w_hit);

endmodule

// File: hdl/pkw_char_encode.sv
module pkw_char_encode (
    input  logic [7:0]            i_char,
    output pkw_pkg::t_char_codes  o_codes
);

    // Map the character onto the lower, upper or punctuation set, or the raw escape.
    always_comb begin
        o_codes = '0;
        case (i_char) inside
            [8'h61:8'h7A]: begin
                o_codes.count   = pkw_pkg::LEN_LOWER;
                o_codes.code[0] = 5'(i_char - 8'h5B);
            end
            [8'h41:8'h5A]: begin
                o_codes.count   = pkw_pkg::LEN_SHIFT;
                o_codes.code[0] = pkw_pkg::SHIFT_UPPER;
                o_codes.code[1] = 5'(i_char - 8'h3B);
            end
            [8'h30:8'h39]: begin
                o_codes.count   = pkw_pkg::LEN_SHIFT;
                o_codes.code[0] = pkw_pkg::SHIFT_PUNCT;
                o_codes.code[1] = 5'(i_char - 8'h28);
            end
            8'h0A, 8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h5F, 8'h23, 8'h27,
            8'h22, 8'h2F, 8'h5C, 8'h2D, 8'h3A, 8'h28, 8'h29: begin
                o_codes.count   = pkw_pkg::LEN_SHIFT;
                o_codes.code[0] = pkw_pkg::SHIFT_PUNCT;
                case (i_char)
                    8'h0A:   o_codes.code[1] = 5'd7;
                    8'h2E:   o_codes.code[1] = 5'd18;
                    8'h2C:   o_codes.code[1] = 5'd19;
                    8'h21:   o_codes.code[1] = 5'd20;
                    8'h3F:   o_codes.code[1] = 5'd21;
                    8'h5F:   o_codes.code[1] = 5'd22;
                    8'h23:   o_codes.code[1] = 5'd23;
                    8'h27:   o_codes.code[1] = 5'd24;
                    8'h22:   o_codes.code[1] = 5'd25;
                    8'h2F:   o_codes.code[1] = 5'd26;
                    8'h5C:   o_codes.code[1] = 5'd27;
                    8'h2D:   o_codes.code[1] = 5'd28;
                    8'h3A:   o_codes.code[1] = 5'd29;
                    8'h28:   o_codes.code[1] = 5'd30;
                    default: o_codes.code[1] = 5'd31;
                endcase
            end
            default: begin
                // Unlisted byte: punctuation shift, escape, then the byte as its top three bits and low five bits.
                o_codes.count   = pkw_pkg::LEN_RAW;
                o_codes.code[0] = pkw_pkg::SHIFT_PUNCT;
                o_codes.code[1] = pkw_pkg::CODE_ESCAPE;
                o_codes.code[2] = {2'b00, i_char[7:5]};
                o_codes.code[3] = i_char[4:0];
            end
        endcase
    end

endmodule

// File: hdl/pkw_word_state.sv
module pkw_word_state #(
    parameter int CODES_PER_WORD = pkw_pkg::CODES_PER_WORD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  pkw_pkg::t_in_word     i_in,
    input  logic                  i_is_break,
    input  pkw_pkg::t_char_codes  i_codes,
    output logic                  o_emit,
    output pkw_pkg::t_out_word    o_out
);

    localparam int UW    = $clog2(CODES_PER_WORD + 1);
    localparam int SW    = UW + 1;
    localparam int WORDS = (CODES_PER_WORD + 2) / 3;

    logic [CODES_PER_WORD-1:0][4:0]  r_buf;
    logic [UW-1:0]                   r_used;
    logic [7:0]                      r_len;

    logic [UW-1:0]                   base_used;
    logic [7:0]                      base_len;
    logic                            add_codes;
    logic [SW-1:0]                   sum_used;
    logic [CODES_PER_WORD-1:0][4:0]  post_buf;
    logic [UW-1:0]                   post_used;
    logic [7:0]                      post_len;
    logic [pkw_pkg::CODES_MAX-1:0][4:0] w_val;
    logic [pkw_pkg::OUT_WORDS-1:0][15:0] w_packed;

    // Start of a new word discards the partial state.
    assign base_used = i_in.word_start ? '0 : r_used;
    assign base_len  = i_in.word_start ? 8'h00 : r_len;

    // A break only contributes its own codes when it is the first character.
    assign add_codes = !i_is_break || (base_len == 8'h00);
    assign sum_used  = SW'(base_used) + SW'(i_codes.count);

    // Place the new codes after those already held, dropping any overflow.
    always_comb begin
        logic [SW-1:0] off;
        for (int p = 0; p < CODES_PER_WORD; p++) begin
            off = SW'(p) - SW'(base_used);
            if (add_codes && (SW'(p) >= SW'(base_used)) && (off < SW'(i_codes.count))) begin
                post_buf[p] = i_codes.code[off[1:0]];
            end else begin
                post_buf[p] = r_buf[p];
            end
        end
    end

    always_comb begin
        if (!add_codes) begin
            post_used = base_used;
        end else if (sum_used > SW'(CODES_PER_WORD)) begin
            post_used = UW'(CODES_PER_WORD);
        end else begin
            post_used = sum_used[UW-1:0];
        end
    end

    // Length counts ordinary characters and saturates; a lone break counts as one.
    always_comb begin
        if (i_is_break) begin
            post_len = (base_len == 8'h00) ? 8'h01 : base_len;
        end else if (base_len == 8'hFF) begin
            post_len = 8'hFF;
        end else begin
            post_len = base_len + 8'h01;
        end
    end

    assign o_emit = i_is_break || i_in.text_end;

    // Unused positions read as the pad code.
    for (genvar p = 0; p < pkw_pkg::CODES_MAX; p++) begin : g_val
        if (p < CODES_PER_WORD) begin : g_held
            assign w_val[p] = (UW'(p) < post_used) ? post_buf[p] : pkw_pkg::CODE_PAD;
        end else begin : g_pad
            assign w_val[p] = pkw_pkg::CODE_PAD;
        end
    end

    // Pack three codes per word, mark the last covered word, zero the rest.
    for (genvar w = 0; w < pkw_pkg::OUT_WORDS; w++) begin : g_word
        if (w + 1 == WORDS) begin : g_last
            assign w_packed[w] = {1'b1, w_val[3*w], w_val[3*w+1], w_val[3*w+2]};
        end else if (w < WORDS) begin : g_mid
            assign w_packed[w] = {1'b0, w_val[3*w], w_val[3*w+1], w_val[3*w+2]};
        end else begin : g_none
            assign w_packed[w] = 16'h0000;
        end
    end

    assign o_out.packed_first   = w_packed[0];
    assign o_out.packed_second  = w_packed[1];
    assign o_out.packed_third   = w_packed[2];
    assign o_out.chars_consumed = post_len;

    // Partial word state; cleared after each finished word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_len  <= 8'h00;
        end else if (i_step) begin
            r_used <= o_emit ? '0 : post_used;
            r_len  <= o_emit ? 8'h00 : post_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_buf <= post_buf;
        end
    end

endmodule

// File: hdl/packed_five_bit_word_encoder.sv
// Words pass from the input register via the encode stage to the result register.
// Throughput: one input word per cycle while the output is not stalled, set by the
// single encode stage between the input register and the result register; a result
// held under stall still lets one more input word be taken into the input register.
// Reset (synchronous, active low) empties both registers, clears the partial word
// and sets both break-list registers to zero.
module packed_five_bit_word_encoder #(
    parameter int CODES_PER_WORD = pkw_pkg::CODES_PER_WORD_DEF,
    parameter int BREAK_SLOTS    = pkw_pkg::BREAK_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pkw_pkg::t_in_word   i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pkw_pkg::t_out_word  o_out_word,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    logic [63:0]           r_break_low;
    logic [63:0]           r_break_high;
    logic                  r_in_valid;
    pkw_pkg::t_in_word     r_in_word;
    logic                  r_out_valid;
    pkw_pkg::t_out_word    r_out_word;

    logic                  in_accept;
    logic                  advance;
    logic                  step;
    logic                  is_break;
    logic                  emit;
    pkw_pkg::t_char_codes  char_codes;
    pkw_pkg::t_out_word    out_next;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_low  <= 64'h0;
            r_break_high <= 64'h0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pkw_pkg::CFG_BREAK_LOW:  r_break_low  <= i_cfg_data;
                pkw_pkg::CFG_BREAK_HIGH: r_break_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The encode stage moves whenever the result register is free or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    pkw_break_detect #(
        .BREAK_SLOTS (BREAK_SLOTS)
    ) u_break (
        .i_break_low  (r_break_low),
        .i_break_high (r_break_high),
        .i_char       (r_in_word.char_byte),
        .o_is_break   (is_break)
    );

    pkw_char_encode u_encode (
        .i_char  (r_in_word.char_byte),
        .o_codes (char_codes)
    );

    pkw_word_state #(
        .CODES_PER_WORD (CODES_PER_WORD)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_in       (r_in_word),
        .i_is_break (is_break),
        .i_codes    (char_codes),
        .o_emit     (emit),
        .o_out      (out_next)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_word <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
